FILE: hw/rtl/cffa_pkg.sv
// Package for the contiguous first-fit block allocator.
// Holds sizes, command and status codes, payload and control types.
// No dependencies.
`default_nettype none

package cffa_pkg;

    localparam int FILES  = 16;
    localparam int BLOCKS = 32;

    localparam int SLOT_W = $clog2(FILES);
    localparam int FC_W   = $clog2(FILES + 1);
    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int CNT_W  = $clog2(BLOCKS + 1);
    localparam int CFG_W  = 6;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_ALLOC  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_ALREADY  = 3'd2;
    localparam logic [2:0] ST_NOSPACE  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] file_id;
        logic [5:0] num_blocks;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] file_id_out;
        logic [4:0] start_block;
        logic [5:0] block_count;
    } t_result;

    typedef struct packed {
        logic             allocated;
        logic [BLK_W-1:0] start;
        logic [CNT_W-1:0] count;
    } t_slot;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_slot             data;
    } t_ram_wr;

    typedef struct packed {
        logic clear;
        logic mark;
        logic start;
    } t_fit_ctl;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [BLK_W-1:0] where;
    } t_fit_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SWEEP,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/cffa_slot_ram.sv
// Slot table memory: one entry per file slot, one write and one read port.
// Registered read data. Depends on cffa_pkg.
`default_nettype none

module cffa_slot_ram (
    input  logic                           i_clk,
    input  cffa_pkg::t_ram_wr              i_wr,
    input  logic [cffa_pkg::SLOT_W-1:0]    i_rd_addr,
    output cffa_pkg::t_slot                o_rd_data
);
    import cffa_pkg::*;

    t_slot mem [FILES];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hw/rtl/cffa_fit_scan.sv
// Occupancy map and first-fit scanner: marks runs from swept slots, then
// walks the blocks one per cycle looking for a free run. Depends on cffa_pkg.
`default_nettype none

module cffa_fit_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cffa_pkg::t_fit_ctl          i_ctl,
    input  cffa_pkg::t_slot             i_slot,
    input  logic [cffa_pkg::CNT_W-1:0]  i_eff,
    input  logic [cffa_pkg::CNT_W-1:0]  i_need,
    output cffa_pkg::t_fit_res          o_res
);
    import cffa_pkg::*;

    logic [BLOCKS-1:0] r_taken;
    logic [BLOCKS-1:0] w_mask;
    logic              r_busy;
    logic [CNT_W-1:0]  r_b;
    logic [CNT_W-1:0]  r_run;
    logic [CNT_W-1:0]  w_run_next;
    logic [CNT_W-1:0]  w_where_full;
    logic              w_at_end;
    logic              w_free;
    logic              w_hit;

    always_comb begin
        for (int b = 0; b < BLOCKS; b++) begin
            w_mask[b] = i_slot.allocated && (b >= int'(i_slot.start))
                        && (b < int'(i_slot.start) + int'(i_slot.count));
        end
    end

    assign w_at_end     = (r_b == i_eff);
    assign w_free       = !r_taken[r_b[BLK_W-1:0]];
    assign w_run_next   = w_free ? r_run + CNT_W'(1) : '0;
    assign w_hit        = !w_at_end && w_free && (w_run_next == i_need);
    assign w_where_full = r_b + CNT_W'(1) - i_need;

    assign o_res.done  = r_busy && (w_at_end || w_hit);
    assign o_res.found = w_hit;
    assign o_res.where = w_where_full[BLK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
        end else if (o_res.done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_taken <= '0;
        end else if (i_ctl.mark) begin
            r_taken <= r_taken | w_mask;
        end
        if (i_ctl.start) begin
            r_b   <= '0;
            r_run <= '0;
        end else if (r_busy) begin
            r_b   <= r_b + CNT_W'(1);
            r_run <= w_run_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/contiguous_first_fit_block_allocator.sv
// Top level of the contiguous first-fit block allocator: command sequencer,
// total_blocks register and result register. Depends on cffa_pkg,
// cffa_slot_ram and cffa_fit_scan.
//
//   channel  | handshake                  | beat
//   ---------+----------------------------+---------------------------
//   command  | i_in_valid / o_in_stall    | i_in_data  (t_cmd_item)
//   result   | o_out_valid / i_out_stall  | o_out_data (t_result)
//   config   | i_cfg_we                   | i_cfg_wdata (total_blocks)
//
// Create and unknown slot finish at decode, query at the slot check.
// Allocate ends at the slot check, or else sweeps the files_created slots
// and then scans up to min(total_blocks, 32) blocks: the slot sweep
// goes through the single table read port, one slot a cycle, and the scan
// walks the occupancy map one block a cycle.
// Reset clears the slot count, not the table; slots are written when created.
// o_in_stall is high while a command is in progress; a finished beat waits in
// the result register while the next command is taken.
`default_nettype none

module contiguous_first_fit_block_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cffa_pkg::t_cmd_item            i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cffa_pkg::t_result              o_out_data,
    input  logic                           i_cfg_we,
    input  logic [cffa_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import cffa_pkg::*;

    t_state           r_state, n_state;
    logic [1:0]       r_cmd, n_cmd;
    logic [3:0]       r_id, n_id;
    logic [5:0]       r_n, n_n;
    logic [FC_W-1:0]  r_fc, n_fc;
    logic [FC_W-1:0]  r_k, n_k;
    t_result          r_res, n_res;
    t_result          r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [CFG_W-1:0] r_total;

    logic [CNT_W-1:0]  w_eff;
    logic [CNT_W-1:0]  w_need;
    logic              w_known;
    logic              w_accept;
    logic              w_out_free;
    t_slot             w_slot;
    t_ram_wr           w_ram_wr;
    logic [SLOT_W-1:0] w_rd_addr;
    t_fit_ctl          w_fit_ctl;
    t_fit_res          w_fit_res;

    assign w_eff      = (r_total > CFG_W'(BLOCKS)) ? CNT_W'(BLOCKS) : CNT_W'(r_total);
    assign w_need     = CNT_W'(r_n);
    assign w_known    = (r_cmd == CMD_ALLOC || r_cmd == CMD_QUERY)
                        && (int'(r_id) < int'(r_fc));
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    cffa_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_ram_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_slot)
    );

    cffa_fit_scan u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fit_ctl),
        .i_slot  (w_slot),
        .i_eff   (w_eff),
        .i_need  (w_need),
        .o_res   (w_fit_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (r_cmd != CMD_CREATE && w_known) n_state = S_CHECK;
                else n_state = S_DONE;
            end
            S_CHECK: begin
                if (r_cmd == CMD_QUERY || w_slot.allocated || r_n == '0
                    || w_need > w_eff) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (r_k == r_fc) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_fit_res.done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_n         = r_n;
        n_fc        = r_fc;
        n_k         = r_k;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_ram_wr    = '0;
        w_rd_addr   = SLOT_W'(r_id);
        w_fit_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = i_in_data.command;
                    n_id  = i_in_data.file_id;
                    n_n   = i_in_data.num_blocks;
                end
            end
            S_DECODE: begin
                if (r_cmd == CMD_CREATE) begin
                    if (r_fc == FC_W'(FILES)) begin
                        n_res = '{ST_FULL, 4'd0, 5'd0, 6'd0};
                    end else begin
                        w_ram_wr.en   = 1'b1;
                        w_ram_wr.addr = r_fc[SLOT_W-1:0];
                        n_fc          = r_fc + FC_W'(1);
                        n_res         = '{ST_OK, 4'(r_fc), 5'd0, 6'd0};
                    end
                end else if (!w_known) begin
                    n_res = '{ST_NOTFOUND, r_id, 5'd0, 6'd0};
                end
            end
            S_CHECK: begin
                if (r_cmd == CMD_QUERY) begin
                    n_res = '{ST_OK, r_id, 5'(w_slot.start), 6'(w_slot.count)};
                end else if (w_slot.allocated) begin
                    n_res = '{ST_ALREADY, r_id, 5'(w_slot.start), 6'(w_slot.count)};
                end else if (r_n == '0) begin
                    w_ram_wr.en             = 1'b1;
                    w_ram_wr.addr           = SLOT_W'(r_id);
                    w_ram_wr.data.allocated = 1'b1;
                    n_res = '{ST_OK, r_id, 5'd0, 6'd0};
                end else if (w_need > w_eff) begin
                    n_res = '{ST_NOSPACE, r_id, 5'd0, 6'd0};
                end else begin
                    w_fit_ctl.clear = 1'b1;
                    w_rd_addr       = '0;
                    n_k             = FC_W'(1);
                end
            end
            S_SWEEP: begin
                w_fit_ctl.mark = 1'b1;
                if (r_k == r_fc) begin
                    w_fit_ctl.start = 1'b1;
                end else begin
                    w_rd_addr = r_k[SLOT_W-1:0];
                    n_k       = r_k + FC_W'(1);
                end
            end
            S_SCAN: begin
                if (w_fit_res.done) begin
                    if (w_fit_res.found) begin
                        w_ram_wr.en   = 1'b1;
                        w_ram_wr.addr = SLOT_W'(r_id);
                        w_ram_wr.data = '{1'b1, w_fit_res.where, w_need};
                        n_res = '{ST_OK, r_id, 5'(w_fit_res.where), r_n};
                    end else begin
                        n_res = '{ST_NOSPACE, r_id, 5'd0, 6'd0};
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fc        <= '0;
            r_out_valid <= 1'b0;
            r_total     <= CFG_W'(BLOCKS);
        end else begin
            r_state     <= n_state;
            r_fc        <= n_fc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_id  <= n_id;
        r_n   <= n_n;
        r_k   <= n_k;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= FC_W'(FILES))
        else $error("slot count beyond table size");

    a_fit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fit_res.done |-> r_state == S_SCAN)
        else $error("scanner finished outside scan state");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished result not loaded into output register");

    a_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_wr.en && r_state != S_DECODE) |-> int'(r_id) < int'(r_fc))
        else $error("slot write to an uncreated slot");

endmodule

`default_nettype wire
